// ===== rtl/lru_page_replacement_defines.svh =====
// assertion macros used by the lru page table core
`ifndef LRU_PAGE_REPLACEMENT_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_DEFINES_SVH

`ifndef SYNTHESIS

// condition holds at every rising clock edge out of reset
`define LRUPR_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define LRUPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LRUPR_ASSERT(label, cond, msg)
`define LRUPR_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== rtl/lrupr_pkg.sv =====
package lrupr_pkg;

    localparam int MAX_SLOTS = 8;
    localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int CFG_W     = 4;
    localparam int PAGE_W    = 8;
    localparam int FAULT_W   = 16;

    localparam logic [CFG_W-1:0] SLOTS_RESET = CFG_W'(4);

    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [PAGE_W-1:0]  page_t;
    typedef logic [FAULT_W-1:0] fault_t;

    typedef struct packed {
        page_t page;
        logic  first_of_string;
    } lrupr_req_t;

    typedef struct packed {
        logic   hit;
        slot_t  slot;
        logic   evicted;
        page_t  evicted_page;
        fault_t fault_count;
    } lrupr_rsp_t;

endpackage

// ===== rtl/lrupr_ref_if.sv =====
interface lrupr_ref_if import lrupr_pkg::*; ();
    logic  valid;
    logic  ready;
    page_t page;
    logic  first_of_string;

    modport source (output valid, output page, output first_of_string, input ready);
    modport sink   (input valid, input page, input first_of_string, output ready);
endinterface

// ===== rtl/lrupr_res_if.sv =====
interface lrupr_res_if import lrupr_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   hit;
    slot_t  slot;
    logic   evicted;
    page_t  evicted_page;
    fault_t fault_count;

    modport source (output valid, output hit, output slot, output evicted,
                    output evicted_page, output fault_count, input ready);
    modport sink   (input valid, input hit, input slot, input evicted,
                    input evicted_page, input fault_count, output ready);
endinterface

// ===== rtl/lrupr_core.sv =====
`include "lru_page_replacement_defines.svh"

module lrupr_core import lrupr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CFG_W-1:0] slots_in_use,
    input  lrupr_req_t       req,
    input  logic             step,
    output lrupr_rsp_t       rsp
);

    localparam slot_t RANK_MAX = '1;

    page_t                 page_reg [MAX_SLOTS];
    logic [MAX_SLOTS-1:0]  valid_reg;
    logic [MAX_SLOTS-1:0]  valid_next;
    slot_t                 rank_reg [MAX_SLOTS];
    slot_t                 rank_next [MAX_SLOTS];
    cnt_t                  filled_reg;
    cnt_t                  filled_next;
    fault_t                fault_reg;
    fault_t                fault_next;

    logic [MAX_SLOTS-1:0]  cur_valid;
    slot_t                 cur_rank [MAX_SLOTS];
    cnt_t                  cur_filled;
    fault_t                cur_fault;
    cnt_t                  cap;
    logic                  hit;
    slot_t                 hit_slot;
    logic                  fill;
    logic                  found;
    slot_t                 lru_slot;
    slot_t                 sel;
    slot_t                 sel_rank;

    always_comb
    begin
        // start of string sees an empty table
        cur_valid  = req.first_of_string ? '0 : valid_reg;
        cur_filled = req.first_of_string ? '0 : filled_reg;
        cur_fault  = req.first_of_string ? '0 : fault_reg;
        for (int j = 0; j < MAX_SLOTS; j++)
        begin
            cur_rank[j] = req.first_of_string ? '0 : rank_reg[j];
        end

        if (slots_in_use == '0)
        begin
            cap = CNT_W'(1);
        end
        else if (32'(slots_in_use) > 32'(MAX_SLOTS))
        begin
            cap = CNT_W'(MAX_SLOTS);
        end
        else
        begin
            cap = CNT_W'(slots_in_use);
        end

        // lowest matching frame wins
        hit      = 1'b0;
        hit_slot = '0;
        for (int j = MAX_SLOTS - 1; j >= 0; j--)
        begin
            if (cur_valid[j] && (page_reg[j] == req.page))
            begin
                hit      = 1'b1;
                hit_slot = SLOT_W'(j);
            end
        end

        // oldest valid frame, lowest frame on a tie
        found    = 1'b0;
        lru_slot = '0;
        for (int j = 0; j < MAX_SLOTS; j++)
        begin
            if (cur_valid[j] && (!found || (cur_rank[j] > cur_rank[lru_slot])))
            begin
                lru_slot = SLOT_W'(j);
                found    = 1'b1;
            end
        end

        fill = !hit && (cur_filled < cap) && (32'(cur_filled) < 32'(MAX_SLOTS));

        if (hit)
        begin
            sel = hit_slot;
        end
        else if (fill)
        begin
            sel = cur_filled[SLOT_W-1:0];
        end
        else
        begin
            sel = lru_slot;
        end
        sel_rank = cur_rank[sel];

        for (int j = 0; j < MAX_SLOTS; j++)
        begin
            rank_next[j] = cur_rank[j];
            if (fill)
            begin
                if (cur_valid[j] && (cur_rank[j] < RANK_MAX))
                begin
                    rank_next[j] = cur_rank[j] + 1'b1;
                end
            end
            else if (cur_valid[j] && (SLOT_W'(j) != sel) && (cur_rank[j] < sel_rank))
            begin
                rank_next[j] = cur_rank[j] + 1'b1;
            end
        end
        rank_next[sel] = '0;

        valid_next = cur_valid;
        if (fill)
        begin
            valid_next[sel] = 1'b1;
        end
        filled_next = cur_filled + CNT_W'(fill);
        fault_next  = (!hit && (cur_fault != '1)) ? cur_fault + 1'b1 : cur_fault;

        rsp.hit          = hit;
        rsp.slot         = sel;
        rsp.evicted      = !hit && !fill;
        rsp.evicted_page = (!hit && !fill) ? page_reg[lru_slot] : '0;
        rsp.fault_count  = fault_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            filled_reg <= '0;
            fault_reg  <= '0;
            for (int j = 0; j < MAX_SLOTS; j++)
            begin
                rank_reg[j] <= '0;
            end
        end
        else if (step)
        begin
            valid_reg  <= valid_next;
            filled_reg <= filled_next;
            fault_reg  <= fault_next;
            for (int j = 0; j < MAX_SLOTS; j++)
            begin
                rank_reg[j] <= rank_next[j];
            end
        end
    end

    // page table, written only on a fault
    always_ff @(posedge clk)
    begin
        if (step && !hit)
        begin
            page_reg[sel] <= req.page;
        end
    end

    `LRUPR_ASSERT(a_filled_bound, 32'(filled_reg) <= 32'(MAX_SLOTS), "fill count beyond frame count")
    `LRUPR_ASSERT(a_valid_count, $countones(valid_reg) == 32'(filled_reg), "valid frames differ from fill count")
    `LRUPR_ASSERT_NEXT(a_sel_newest, step, valid_reg[$past(rsp.slot)] && (rank_reg[$past(rsp.slot)] == '0), "referenced frame not most recent")

endmodule

// ===== rtl/lru_page_replacement.sv =====
// channel  | dir | payload                                             | handshake
// refs     | in  | page, first_of_string                               | valid/ready
// result   | out | hit, slot, evicted, evicted_page, fault_count       | valid/ready
// cfg      | in  | cfg_wdata (slots_in_use)                            | cfg_we
//
// one request per cycle when results are taken; a taken request waits in the input register
// the table update sits between the input register and the result register, one pass per request
// reset empties the table, zeroes the fault count and sets slots_in_use to four; no clearing pass
// a result that is not taken holds the result register; the input register then holds its request
// and refs.ready drops only while both registers are full and stalled

module lru_page_replacement import lrupr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    lrupr_ref_if.sink        refs,
    lrupr_res_if.source      result,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata
);

    logic [CFG_W-1:0] slots_reg;
    logic             in_vld_reg;
    lrupr_req_t       in_req_reg;
    logic             out_vld_reg;
    lrupr_rsp_t       out_rsp_reg;
    lrupr_rsp_t       rsp;
    logic             advance;

    assign advance    = in_vld_reg && (!out_vld_reg || result.ready);
    assign refs.ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= SLOTS_RESET;
        end
        else if (cfg_we)
        begin
            slots_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (refs.ready)
            begin
                in_vld_reg <= refs.valid;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (refs.ready && refs.valid)
        begin
            in_req_reg.page            <= refs.page;
            in_req_reg.first_of_string <= refs.first_of_string;
        end
        if (advance)
        begin
            out_rsp_reg <= rsp;
        end
    end

    lrupr_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .slots_in_use (slots_reg),
        .req          (in_req_reg),
        .step         (advance),
        .rsp          (rsp)
    );

    assign result.valid        = out_vld_reg;
    assign result.hit          = out_rsp_reg.hit;
    assign result.slot         = out_rsp_reg.slot;
    assign result.evicted      = out_rsp_reg.evicted;
    assign result.evicted_page = out_rsp_reg.evicted_page;
    assign result.fault_count  = out_rsp_reg.fault_count;

endmodule

// ===== bench/lru_page_replacement_test.sv =====
module lru_page_replacement_test import lrupr_pkg::*; ();

    localparam int CLK_PERIOD = 12;
    localparam fault_t FAULT_CEIL = '1;

    class frame_table_tracker;
        page_t            frame_page [MAX_SLOTS];
        logic             frame_used [MAX_SLOTS];
        logic [2:0]       frame_age  [MAX_SLOTS];
        int               frames_filled;
        fault_t           faults;
        logic [CFG_W-1:0] capacity;
        lrupr_rsp_t       expected_results [$];
        int               error_count;

        function new();
            capacity    = SLOTS_RESET;
            error_count = 0;
            clear_frames();
        endfunction

        function void clear_frames();
            foreach (frame_used[j])
            begin
                frame_page[j] = '0;
                frame_used[j] = 1'b0;
                frame_age[j]  = '0;
            end
            frames_filled = 0;
            faults        = '0;
        endfunction

        function void set_capacity(logic [CFG_W-1:0] value);
            capacity = value;
        endfunction

        // younger valid frames age by one, the touched frame becomes rank 0
        function void make_newest(int s);
            logic [2:0] r;
            r = frame_age[s];
            for (int j = 0; j < MAX_SLOTS; j++)
                if (frame_used[j] && j != s && frame_age[j] < r)
                    frame_age[j] = frame_age[j] + 3'd1;
            frame_age[s] = '0;
        endfunction

        function void take_request(page_t pg, logic fos);
            int         lim;
            int         s;
            bit         is_hit;
            bit         found;
            bit         ev;
            page_t      evp;
            lrupr_rsp_t want;
            if (fos)
                clear_frames();
            lim = capacity;
            if (lim < 1)
                lim = 1;
            if (lim > MAX_SLOTS)
                lim = MAX_SLOTS;
            is_hit = 1'b0;
            ev     = 1'b0;
            evp    = '0;
            s      = 0;
            for (int j = 0; j < MAX_SLOTS; j++)
                if (!is_hit && frame_used[j] && frame_page[j] == pg)
                begin
                    is_hit = 1'b1;
                    s      = j;
                end
            if (is_hit)
                make_newest(s);
            else
            begin
                if (frames_filled < lim)
                begin
                    s = frames_filled;
                    for (int j = 0; j < MAX_SLOTS; j++)
                        if (frame_used[j] && frame_age[j] < 3'd7)
                            frame_age[j] = frame_age[j] + 3'd1;
                    frame_used[s] = 1'b1;
                    frame_age[s]  = '0;
                    frame_page[s] = pg;
                    frames_filled++;
                end
                else
                begin
                    // lru among every valid frame, lowest frame on a tie
                    found = 1'b0;
                    for (int j = 0; j < MAX_SLOTS; j++)
                        if (frame_used[j] && (!found || frame_age[j] > frame_age[s]))
                        begin
                            s     = j;
                            found = 1'b1;
                        end
                    ev            = 1'b1;
                    evp           = frame_page[s];
                    frame_page[s] = pg;
                    make_newest(s);
                end
                if (faults != FAULT_CEIL)
                    faults = faults + 1'b1;
            end
            want.hit          = is_hit;
            want.slot         = slot_t'(s);
            want.evicted      = ev;
            want.evicted_page = evp;
            want.fault_count  = faults;
            expected_results = {expected_results, want};
        endfunction

        function void report(string what, lrupr_rsp_t want, lrupr_rsp_t got);
            error_count++;
            if (error_count <= 10)
                $display("%0t %s: expected hit=%0b slot=%0d ev=%0b evp=%02h faults=%0d, got hit=%0b slot=%0d ev=%0b evp=%02h faults=%0d",
                         $realtime, what, want.hit, want.slot, want.evicted, want.evicted_page,
                         want.fault_count, got.hit, got.slot, got.evicted, got.evicted_page,
                         got.fault_count);
        endfunction

        function void check_result(lrupr_rsp_t got);
            lrupr_rsp_t want;
            if (expected_results.size() == 0)
            begin
                report("result with no request outstanding", '0, got);
                return;
            end
            want = expected_results.pop_front();
            if (got.hit !== want.hit || got.slot !== want.slot || got.evicted !== want.evicted
                || got.evicted_page !== want.evicted_page || got.fault_count !== want.fault_count)
                report("result mismatch", want, got);
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    lrupr_ref_if ref_bus ();
    lrupr_res_if res_bus ();

    frame_table_tracker tracker = new();

    int burst_left    = 0;
    bit sender_steady = 1'b0;
    bit hold_request  = 1'b0;

    lru_page_replacement u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .refs      (ref_bus),
        .result    (res_bus),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (ref_bus.valid && ref_bus.ready)
                tracker.take_request(ref_bus.page, ref_bus.first_of_string);
            if (res_bus.valid && res_bus.ready)
                tracker.check_result('{hit: res_bus.hit, slot: res_bus.slot,
                                       evicted: res_bus.evicted,
                                       evicted_page: res_bus.evicted_page,
                                       fault_count: res_bus.fault_count});
        end
    end

    // result side: own stall pattern, plus a long hold-off when asked
    initial
    begin
        int mode;
        int left;
        int hold_left;
        mode      = 0;
        left      = 0;
        hold_left = 0;
        res_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = 48;
            end
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(16, 80);
            end
            left--;
            if (hold_left > 0)
            begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0: res_bus.ready <= 1'b1;
                    1: res_bus.ready <= ($urandom_range(0, 99) >= 30);
                    2: res_bus.ready <= ((left % 5) < 3);
                    default: res_bus.ready <= ($urandom_range(0, 99) >= 75);
                endcase
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_ref(input page_t pg, input logic fos);
        int pause;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            pause      = sender_steady ? 0 : $urandom_range(0, 6);
            if (pause > 0)
            begin
                ref_bus.valid <= 1'b0;
                repeat (pause) @(negedge clk);
            end
        end
        burst_left--;
        ref_bus.valid           <= 1'b1;
        ref_bus.page            <= pg;
        ref_bus.first_of_string <= fos;
        do
            @(posedge clk);
        while (!ref_bus.ready);
        @(negedge clk);
    endtask

    task automatic drain_table();
        ref_bus.valid <= 1'b0;
        while (tracker.expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        tracker.set_capacity(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        logic [CFG_W-1:0] phase_caps [10];
        int               pool_base;
        int               pool_span;
        int               waited;
        page_t            pg;
        logic             fos;
        phase_caps = '{4'd8, 4'd3, 4'd1, 4'd0, 4'd15, 4'd5, 4'd2, 4'd7, 4'd6, 4'd4};
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_wdata               = '0;
        ref_bus.valid           = 1'b0;
        ref_bus.page            = '0;
        ref_bus.first_of_string = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset capacity of four: fill, hit, then lru replacement
        send_ref(8'h00, 1'b1);
        send_ref(8'hFF, 1'b0);
        send_ref(8'h00, 1'b0);
        send_ref(8'h01, 1'b0);
        send_ref(8'h02, 1'b0);
        send_ref(8'h03, 1'b0);
        send_ref(8'h02, 1'b0);
        send_ref(8'hFF, 1'b0);

        // capacity lowered below the resident count
        drain_table();
        write_capacity(4'd2);
        send_ref(8'h01, 1'b0);
        send_ref(8'h00, 1'b0);
        send_ref(8'h64, 1'b0);

        // zero capacity acts as one
        drain_table();
        write_capacity(4'd0);
        send_ref(8'h64, 1'b0);
        send_ref(8'h65, 1'b0);
        send_ref(8'h55, 1'b1);
        send_ref(8'hAA, 1'b0);

        // capacity above the frame count acts as the full table
        drain_table();
        write_capacity(4'd15);
        for (int i = 0; i < 9; i++)
            send_ref(page_t'(8'hF0 + i), 1'b0);

        foreach (phase_caps[p])
        begin
            drain_table();
            write_capacity(phase_caps[p]);
            if (p == 3)
            begin
                // stall the result side while requests keep coming
                sender_steady = 1'b1;
                hold_request  = 1'b1;
            end
            pool_base = $urandom_range(0, 255);
            pool_span = $urandom_range(2, 12);
            for (int i = 0; i < 45; i++)
            begin
                if ($urandom_range(0, 99) < 80)
                    pg = page_t'(pool_base + $urandom_range(0, pool_span - 1));
                else
                    pg = page_t'($urandom_range(0, 255));
                fos = (i == 0) ? ($urandom_range(0, 99) < 50) : ($urandom_range(0, 29) == 0);
                send_ref(pg, fos);
            end
            sender_steady = 1'b0;
        end

        ref_bus.valid <= 1'b0;
        waited = 0;
        while (tracker.expected_results.size() != 0 && waited < 5000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (10) @(negedge clk);
        tracker.error_count += tracker.expected_results.size();
        if (tracker.error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #(CLK_PERIOD * 1000000);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
